>>> src/blfa_pkg.sv
// Shared types, codes and helpers for the bitmap lowest-free ID allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package blfa_pkg;

    // Word address width: covers a clamped word count of up to 127.
    localparam int WORD_AW   = 7;
    localparam int WORD_BITS = 64;
    localparam int BIT_AW    = 6;
    localparam int ID_W      = 12;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_INVALID      = 2'd1,
        STAT_ALREADY_FREE = 2'd2,
        STAT_FULL         = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MODIFY,
        S_SCAN,
        S_FIND
    } state_t;

    typedef struct packed {
        logic                 rd_en;
        logic [WORD_AW-1:0]   rd_addr;
        logic                 wr_en;
        logic [WORD_AW-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic               en;
        logic [WORD_AW-1:0] addr;
        logic               full;
    } full_upd_t;

    typedef struct packed {
        logic               found;
        logic [WORD_AW-1:0] index;
    } scan_res_t;

    // Lowest clear bit; an all-ones word gives the top bit position.
    function automatic logic [BIT_AW-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
        logic [BIT_AW-1:0] pos;
        pos = BIT_AW'(WORD_BITS - 1);
        for (int i = WORD_BITS - 2; i >= 0; i--) begin
            if (!word[i]) begin
                pos = BIT_AW'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

>>> src/bitmap_lowest_free_id_allocator_core.sv
// Top level of the bitmap lowest-free ID allocator: request sequencer and pointer state.
// Uses blfa_pkg, blfa_word_mem and blfa_free_scan.
//
//  channel   signals                         flow
//  request   start, busy, req_type, id       taken when start is high and busy low
//  result    done, status, granted_id        one-cycle strobe, one result per request
//  config    cfg_we, cfg_wdata               words_in_use, written when cfg_we is high
//
// An allocate reads the word, writes it back, searches the full-word vector,
// then reads the found word for its lowest clear bit (skipped when no word is
// left free); a free reads and writes back, a rejected request does neither.
// The result strobes in the cycle after the write back. A config write rescans
// from word 0 with busy high (no find step if no word is free). Reset clears
// the bitmap through per-word valid bits; no clearing pass. No result stalls.
`default_nettype none

module bitmap_lowest_free_id_allocator_core
    import blfa_pkg::*;
#(
    parameter int MAX_WORDS = 64
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic            req_type,
    input  wire logic [ID_W-1:0] id,
    output logic                 done,
    output logic [1:0]           status,
    output logic [ID_W-1:0]      granted_id,
    input  wire logic            cfg_we,
    input  wire logic [6:0]      cfg_wdata
);

    localparam int DEPTH = (MAX_WORDS < 127) ? MAX_WORDS : 127;
    localparam logic [WORD_AW-1:0] DEPTH_W = WORD_AW'(DEPTH);

    state_t              state_reg, state_next;
    logic [6:0]          words_reg, words_next;
    logic [WORD_AW-1:0]  next_word_reg, next_word_next;
    logic [BIT_AW-1:0]   next_bit_reg, next_bit_next;
    logic                none_free_reg, none_free_next;
    logic                req_free_reg, req_free_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [WORD_AW-1:0]  scan_from_reg, scan_from_next;
    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [ID_W-1:0]     granted_reg, granted_next;

    logic [WORD_AW-1:0]   word_count;
    logic [WORD_AW-1:0]   in_word;
    logic                 alloc_full;
    logic                 free_bad;
    logic                 need_read;
    logic [WORD_AW-1:0]   free_word;
    logic [BIT_AW-1:0]    free_bit;
    logic                 lower_ptr;
    mem_req_t             mem_req;
    logic [WORD_BITS-1:0] rd_data;
    full_upd_t            full_upd;
    scan_res_t            scan_res;

    blfa_word_mem #(.DEPTH(DEPTH)) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    blfa_free_scan #(.DEPTH(DEPTH)) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (full_upd),
        .scan_from  (scan_from_reg),
        .word_count (word_count),
        .res        (scan_res)
    );

    // Clamp the word count to 1..DEPTH
    assign word_count = (words_reg == 7'd0) ? WORD_AW'(1) :
                        ((WORD_AW'(words_reg) > DEPTH_W) ? DEPTH_W : WORD_AW'(words_reg));

    assign in_word    = WORD_AW'(id[ID_W-1:BIT_AW]);
    assign alloc_full = none_free_reg || (next_word_reg >= word_count);
    assign free_bad   = in_word >= word_count;
    assign need_read  = (req_type == REQ_ALLOC) ? !alloc_full : !free_bad;

    assign free_word = WORD_AW'(id_reg[ID_W-1:BIT_AW]);
    assign free_bit  = id_reg[BIT_AW-1:0];
    assign lower_ptr = none_free_reg || (free_word < next_word_reg) ||
                       ((free_word == next_word_reg) && (free_bit < next_bit_reg));

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign granted_id = granted_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && need_read)
                begin
                    state_next = S_MODIFY;
                end
            end
            S_MODIFY:
            begin
                state_next = (req_free_reg == REQ_ALLOC) ? S_SCAN : S_IDLE;
            end
            S_SCAN:
            begin
                state_next = scan_res.found ? S_FIND : S_IDLE;
            end
            S_FIND:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // A new size restarts the search from word 0
        if (cfg_we)
        begin
            state_next = S_SCAN;
        end
    end

    always_comb
    begin
        words_next     = words_reg;
        next_word_next = next_word_reg;
        next_bit_next  = next_bit_reg;
        none_free_next = none_free_reg;
        req_free_next  = req_free_reg;
        id_next        = id_reg;
        scan_from_next = scan_from_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        granted_next   = granted_reg;
        mem_req        = '0;
        full_upd       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_free_next = req_type;
                    id_next       = id;
                    if (!need_read)
                    begin
                        done_next    = 1'b1;
                        status_next  = (req_type == REQ_ALLOC) ? STAT_FULL : STAT_INVALID;
                        granted_next = '0;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = (req_type == REQ_ALLOC) ? next_word_reg : in_word;
                    end
                end
            end
            S_MODIFY:
            begin
                if (req_free_reg == REQ_ALLOC)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = next_word_reg;
                    mem_req.wr_data = rd_data | (WORD_BITS'(1) << next_bit_reg);
                    full_upd.en     = 1'b1;
                    full_upd.addr   = next_word_reg;
                    full_upd.full   = &mem_req.wr_data;
                    done_next       = 1'b1;
                    status_next     = STAT_OK;
                    granted_next    = {next_word_reg[BIT_AW-1:0], next_bit_reg};
                    scan_from_next  = next_word_reg;
                end
                else if (!rd_data[free_bit])
                begin
                    done_next    = 1'b1;
                    status_next  = STAT_ALREADY_FREE;
                    granted_next = '0;
                end
                else
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = free_word;
                    mem_req.wr_data = rd_data & ~(WORD_BITS'(1) << free_bit);
                    full_upd.en     = 1'b1;
                    full_upd.addr   = free_word;
                    full_upd.full   = 1'b0;
                    done_next       = 1'b1;
                    status_next     = STAT_OK;
                    granted_next    = '0;
                    if (lower_ptr)
                    begin
                        next_word_next = free_word;
                        next_bit_next  = free_bit;
                        none_free_next = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_res.found)
                begin
                    next_word_next  = scan_res.index;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_res.index;
                end
                else
                begin
                    next_word_next = '0;
                    next_bit_next  = '0;
                    none_free_next = 1'b1;
                end
            end
            S_FIND:
            begin
                next_bit_next  = lowest_zero(rd_data);
                none_free_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            words_next     = cfg_wdata;
            scan_from_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            words_reg     <= 7'd64;
            next_word_reg <= '0;
            next_bit_reg  <= '0;
            none_free_reg <= 1'b0;
            scan_from_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            words_reg     <= words_next;
            next_word_reg <= next_word_next;
            next_bit_reg  <= next_bit_next;
            none_free_reg <= none_free_next;
            scan_from_reg <= scan_from_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_free_reg <= req_free_next;
        id_reg       <= id_next;
        status_reg   <= status_next;
        granted_reg  <= granted_next;
    end

endmodule

`default_nettype wire

>>> src/blfa_word_mem.sv
// Bitmap word store: one 64-bit word per entry, registered read.
// Per-entry valid bits make unwritten entries read as all free. Uses blfa_pkg.
`default_nettype none

module blfa_word_mem
    import blfa_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mem_req_t             req,
    output logic [WORD_BITS-1:0]      rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk) begin
        if (req.wr_en) begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.rd_addr[AW-1:0]];
            end
        end
    end

    // Never-written words are all free
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> src/blfa_free_scan.sv
// Per-word full summary vector and priority encoder for the next non-full word.
// Uses blfa_pkg; driven by the allocator core.
`default_nettype none

module blfa_free_scan
    import blfa_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire full_upd_t          upd,
    input  wire logic [WORD_AW-1:0] scan_from,
    input  wire logic [WORD_AW-1:0] word_count,
    output scan_res_t               res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0] full_reg;
    logic [DEPTH-1:0] cand;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            full_reg <= '0;
        end
        else if (upd.en) begin
            full_reg[upd.addr[AW-1:0]] <= upd.full;
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cand[i] = !full_reg[i] && (WORD_AW'(i) >= scan_from) &&
                      (WORD_AW'(i) < word_count);
        end
    end

    // Lowest candidate word wins
    always_comb begin
        res.found = |cand;
        res.index = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (cand[i]) begin
                res.index = WORD_AW'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> dv/blfa_alloc_checker.sv
`timescale 1ns / 1ps
// Checker for the bitmap lowest-free ID allocator: watches request, result and size writes.
// Keeps its own copy of the bitmap and pointer, predicts each result and compares in order.
// Depends on blfa_pkg for the status codes, request kinds and widths.
module blfa_alloc_checker
    import blfa_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            busy,
    input  wire logic            req_type,
    input  wire logic [ID_W-1:0] id,
    input  wire logic            done,
    input  wire logic [1:0]      status,
    input  wire logic [ID_W-1:0] granted_id,
    input  wire logic            cfg_we,
    input  wire logic [6:0]      cfg_wdata,
    output int                   error_count,
    output int                   pending
);

    localparam int MAP_WORDS = 64;

    typedef struct packed {
        status_t         status;
        logic [ID_W-1:0] granted;
    } outcome_t;

    logic [WORD_BITS-1:0] id_map [MAP_WORDS];
    logic [5:0]           ptr_word;
    logic [5:0]           ptr_bit;
    logic                 map_full;
    logic [6:0]           size_words;

    outcome_t outcome_q[$];
    int       mismatches;
    int       waiting;

    assign error_count = mismatches;
    assign pending     = waiting;

    function automatic int words_active();
        if (size_words == 7'd0)
            return 1;
        if (size_words > 7'(MAP_WORDS))
            return MAP_WORDS;
        return int'(size_words);
    endfunction

    function automatic logic [5:0] first_clear(input logic [WORD_BITS-1:0] w);
        int b;
        b = 0;
        while (b < WORD_BITS - 1 && w[b])
            b++;
        return 6'(b);
    endfunction

    // Point at the lowest clear bit from word 'from' upward; flag full if none.
    task automatic seek_free(input int from);
        int n;
        n = words_active();
        for (int i = from; i < n; i++) begin
            if (id_map[i] != '1) begin
                ptr_word = 6'(i);
                ptr_bit  = first_clear(id_map[i]);
                map_full = 1'b0;
                return;
            end
        end
        ptr_word = '0;
        ptr_bit  = '0;
        map_full = 1'b1;
    endtask

    task automatic grant_or_release(input logic kind, input logic [ID_W-1:0] ident,
                                    output outcome_t res);
        int         n;
        logic [5:0] w;
        logic [5:0] b;
        n = words_active();
        res.status  = STAT_OK;
        res.granted = '0;
        if (kind == REQ_ALLOC) begin
            if (map_full || int'(ptr_word) >= n) begin
                res.status = STAT_FULL;
                return;
            end
            res.granted = {ptr_word, ptr_bit};
            id_map[ptr_word][ptr_bit] = 1'b1;
            seek_free(int'(ptr_word));
        end
        else begin
            w = ident[11:6];
            b = ident[5:0];
            if (int'(w) >= n) begin
                res.status = STAT_INVALID;
                return;
            end
            if (!id_map[w][b]) begin
                res.status = STAT_ALREADY_FREE;
                return;
            end
            id_map[w][b] = 1'b0;
            if (map_full || w < ptr_word || (w == ptr_word && b < ptr_bit)) begin
                ptr_word = w;
                ptr_bit  = b;
                map_full = 1'b0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n) begin
            for (int i = 0; i < MAP_WORDS; i++)
                id_map[i] = '0;
            ptr_word   = '0;
            ptr_bit    = '0;
            map_full   = 1'b0;
            size_words = 7'd64;
            outcome_q.delete();
            mismatches = 0;
            waiting    = 0;
        end
        else begin
            // retire the result of this cycle before taking a new request
            if (done) begin
                got.status  = status_t'(status);
                got.granted = granted_id;
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing outstanding: status %0d granted_id %0d",
                             $realtime, status, granted_id);
                end
                else begin
                    want = outcome_q.pop_front();
                    waiting--;
                    if (got.status != want.status) begin
                        mismatches++;
                        $display("%0t: status mismatch: expected %s actual %0d",
                                 $realtime, want.status.name(), status);
                    end
                    if (got.granted != want.granted) begin
                        mismatches++;
                        $display("%0t: granted_id mismatch: expected %0d actual %0d",
                                 $realtime, want.granted, granted_id);
                    end
                end
            end
            if (start && !busy) begin
                grant_or_release(req_type, id, want);
                outcome_q.push_back(want);
                waiting++;
            end
            if (cfg_we) begin
                size_words = cfg_wdata;
                seek_free(0);
            end
        end
    end

endmodule

>>> dv/bitmap_lowest_free_id_allocator_core_tb.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, directed and random requests, size writes.
// Instantiates bitmap_lowest_free_id_allocator_core and blfa_alloc_checker; uses blfa_pkg.
module bitmap_lowest_free_id_allocator_core_tb;
    import blfa_pkg::*;

    localparam int CYCLE_LIMIT = 80000;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic            req_type;
    logic [ID_W-1:0] id;
    logic            done;
    logic [1:0]      status;
    logic [ID_W-1:0] granted_id;
    logic            cfg_we;
    logic [6:0]      cfg_wdata;
    int              error_count;
    int              pending;
    int              cycles = 0;
    int              ids_in_range;

    bitmap_lowest_free_id_allocator_core #(
        .MAX_WORDS(64)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .id        (id),
        .done      (done),
        .status    (status),
        .granted_id(granted_id),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    blfa_alloc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .id         (id),
        .done       (done),
        .status     (status),
        .granted_id (granted_id),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .error_count(error_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold start high until the request is taken; optionally drop it for a gap first.
    task automatic issue(input logic kind, input logic [ID_W-1:0] ident, input int idle_pct);
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap   = $urandom_range(1, 6);
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    = 1'b1;
        req_type = kind;
        id       = ident;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start = 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_size(input logic [6:0] words);
        drain_results();
        cfg_we    = 1'b1;
        cfg_wdata = words;
        @(negedge clk);
        cfg_we    = 1'b0;
        ids_in_range = (words == 7'd0) ? 64 : (words > 7'd64) ? 4096 : int'(words) * 64;
        repeat (3) @(negedge clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 15)
            return ID_W'($urandom_range(0, 4095));
        return ID_W'($urandom_range(0, ids_in_range - 1));
    endfunction

    // Traffic in bursts: fill runs, drain runs and even mixes, so the map reaches full.
    task automatic random_traffic(input int count, input int idle_pct);
        int alloc_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       alloc_pct = 90;
                    1:       alloc_pct = 20;
                    default: alloc_pct = 50;
                endcase
            end
            if ($urandom_range(0, 99) < alloc_pct)
                issue(REQ_ALLOC, ID_W'($urandom_range(0, 4095)), idle_pct);
            else
                issue(REQ_FREE, pick_id(), idle_pct);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_ALLOC;
        id           = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        ids_in_range = 4096;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // full size after reset: lowest-first grants, double free, top id
        issue(REQ_ALLOC, 12'd0, 0);
        issue(REQ_ALLOC, 12'd4095, 0);
        issue(REQ_ALLOC, 12'd0, 0);
        issue(REQ_FREE, 12'd1, 0);
        issue(REQ_FREE, 12'd1, 0);
        issue(REQ_ALLOC, 12'd0, 0);
        issue(REQ_FREE, 12'd4095, 0);
        issue(REQ_FREE, 12'd0, 0);
        issue(REQ_FREE, 12'd0, 0);
        issue(REQ_ALLOC, 12'd0, 0);

        // one word: ids past the size are rejected
        set_size(7'd1);
        issue(REQ_FREE, 12'd64, 0);
        issue(REQ_FREE, 12'd4095, 0);
        issue(REQ_FREE, 12'd63, 0);
        issue(REQ_ALLOC, 12'd0, 0);

        // oversize values clamp to the full store
        set_size(7'd127);
        issue(REQ_ALLOC, 12'd0, 0);
        issue(REQ_FREE, 12'd2, 0);
        issue(REQ_ALLOC, 12'd0, 0);
        set_size(7'd65);
        issue(REQ_FREE, 12'd4032, 0);
        issue(REQ_FREE, 12'd4095, 0);

        set_size(7'd1);
        random_traffic(215, 29);
        set_size(7'd2);
        random_traffic(215, 73);
        set_size(7'd0);
        random_traffic(110, 0);
        set_size(7'd127);
        random_traffic(105, 0);

        drain_results();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
